// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the codec modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/dtsc_pkg.sv =====
// Types and constants for the date/time stamp codec.
package dtsc_pkg;
   localparam int unsigned EPOCH_SKIP  = 36218;
   localparam int unsigned QUAD_DAYS   = 1461;
   localparam int unsigned TIME_MUL    = 93207;

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   typedef struct packed {
      logic [31:0] in_stamp;
      logic [5:0]  in_second;
      logic [5:0]  in_minute;
      logic [4:0]  in_hour;
      logic [4:0]  in_day;
      logic [3:0]  in_month;
      logic [7:0]  in_year;
      action_type  action;
   } item_type;

   typedef struct packed {
      logic [5:0]  out_second;
      logic [5:0]  out_minute;
      logic [4:0]  out_hour;
      logic [2:0]  out_weekday;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [7:0]  out_year;
      logic [31:0] out_stamp;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENC_MONTH,
      ST_ENC_TIME,
      ST_ENC_DONE,
      ST_DEC_QUAD,
      ST_DEC_YEAR,
      ST_DEC_MONTH,
      ST_DEC_HOUR,
      ST_DEC_MIN,
      ST_DEC_SEC,
      ST_DONE
   } state_type;

   function automatic logic [4:0] tail_month_len(input logic [3:0] m);
      logic b;
      b = m[3] ? ~m[0] : m[0];
      return 5'd30 + {4'd0, b};
   endfunction

   // 8 is 1 mod 7, so the octal digits can simply be summed and folded
   function automatic logic [2:0] mod7_16(input logic [15:0] v);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = {3'd0, v[2:0]} + {3'd0, v[5:3]} + {3'd0, v[8:6]} + {3'd0, v[11:9]}
         + {3'd0, v[14:12]} + {5'd0, v[15]};
      s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
      s3 = {1'b0, s2[2:0]} + {3'd0, s2[3]};
      return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
   endfunction
endpackage

// ===== rtl/dtsc_fifo.sv =====
// Two-entry queue between the front end and the conversion engine.
module dtsc_fifo import dtsc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_data,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_data
);
   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       wr_en, rd_en;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign wr_en    = wr_valid && wr_ready;
   assign rd_en    = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ wr_en;
      rptr_in  = rptr_ff ^ rd_en;
      count_in = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   `include "assert_macros.svh"
   `ASSERT_CLK(a_count_max, clock, reset, (count_ff <= 2'd2), "queue count overflow")
   `ASSERT_CLK(a_count_step, clock, reset,
      (wr_en && !rd_en) |=> (count_ff == $past(count_ff) + 2'd1), "queue count step")
   `ASSERT_CLK(a_ptr_gap, clock, reset,
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wptr_ff == rptr_ff), "queue ptr mismatch")
endmodule

// ===== rtl/dtsc_engine.sv =====
// Sequential conversion engine: calendar loops and fraction multiplies.
module dtsc_engine import dtsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);
   state_type   state_ff, state_in;
   item_type    item_ff, item_in;
   logic [15:0] nr_ff, nr_in;
   logic [7:0]  x_ff, x_in;
   logic [3:0]  mon_ff, mon_in;
   logic [15:0] frac_ff, frac_in;
   result_type  res_ff, res_in;

   logic [15:0] ym1, base, tlen16, nr_adj;
   logic [31:0] tprod;
   logic [21:0] fprod;
   logic [8:0]  ylen;
   logic [6:0]  spart;
   logic        xleap;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      nr_ff   <= nr_in;
      x_ff    <= x_in;
      mon_ff  <= mon_in;
      frac_ff <= frac_in;
      res_ff  <= res_in;
   end

   assign in_ready   = (state_ff == ST_IDLE);
   assign out_valid  = (state_ff == ST_DONE);
   assign out_result = res_ff;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      nr_in    = nr_ff;
      x_in     = x_ff;
      mon_in   = mon_ff;
      frac_in  = frac_ff;
      res_in   = res_ff;
      ym1      = {8'd0, item_ff.in_year} - 16'd1;
      base     = 16'(ym1 * 16'd365) + {{2{ym1[15]}}, ym1[15:2]};
      if (ym1[15] && (ym1[1:0] != 2'b00)) base = base + 16'd1;
      tlen16   = {11'd0, tail_month_len(mon_ff)};
      nr_adj   = 16'd0;
      tprod    = {16'd0, nr_ff} * 32'(TIME_MUL);
      spart    = 7'(((8'({2'b00, item_ff.in_second}) + 8'd1) * 8'd3) >> 2);
      xleap    = (x_ff[1:0] == 2'b00);
      ylen     = xleap ? 9'd366 : 9'd365;
      fprod    = 22'd0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               item_in = in_item;
               res_in  = '0;
               mon_in  = 4'd0;
               state_in = (in_item.action == ACT_ENCODE) ? ST_ENC_MONTH : ST_DEC_QUAD;
               if (in_item.action == ACT_DECODE) begin
                  nr_in = in_item.in_stamp[31:16];
                  res_in.out_weekday = mod7_16(in_item.in_stamp[31:16]);
                  if (in_item.in_stamp[31:16] >= 16'(EPOCH_SKIP))
                     nr_in = in_item.in_stamp[31:16] + 16'd1;
                  x_in = 8'd1;
               end
            end
         end
         ST_ENC_MONTH: begin
            // month offsets summed one month per cycle, mon_ff counts down
            if (mon_ff == 4'd0) begin
               nr_in  = base;
               mon_in = item_ff.in_month - 4'd1;
               if (item_ff.in_month == 4'd2) begin
                  nr_in = base + 16'd31;
                  mon_in = 4'd1;
               end else if (item_ff.in_month != 4'd1) begin
                  nr_in = base + ((item_ff.in_year[1:0] != 2'b00) ? 16'd59 : 16'd60);
                  if (item_ff.in_month <= 4'd3) mon_in = 4'd1;
               end else begin
                  mon_in = 4'd1;
               end
               if (item_ff.in_month > 4'd3) mon_in = item_ff.in_month - 4'd1;
               else mon_in = 4'd15;
               x_in = 8'd1;
            end else if (mon_ff >= 4'd3 && mon_ff != 4'd15) begin
               nr_in  = nr_ff + tlen16;
               mon_in = mon_ff - 4'd1;
            end else begin
               nr_adj = (nr_ff > 16'(EPOCH_SKIP)) ? 16'd1 : 16'd0;
               res_in.out_stamp[31:16] = nr_ff + {11'd0, item_ff.in_day} - 16'd1 - nr_adj;
               nr_in  = 16'(6'd0) + 16'(item_ff.in_hour) * 16'd60 + {10'd0, item_ff.in_minute};
               mon_in = 4'd0;
               state_in = ST_ENC_TIME;
            end
         end
         ST_ENC_TIME: begin
            res_in.out_stamp[15:0] = tprod[26:11] + {9'd0, spart};
            state_in = ST_DONE;
         end
         ST_DEC_QUAD: begin
            if (nr_ff >= 16'(QUAD_DAYS)) begin
               nr_in = nr_ff - 16'(QUAD_DAYS);
               x_in  = x_ff + 8'd4;
            end else begin
               state_in = ST_DEC_YEAR;
            end
         end
         ST_DEC_YEAR: begin
            if (nr_ff >= {7'd0, ylen}) begin
               nr_in = nr_ff - {7'd0, ylen};
               x_in  = x_ff + 8'd1;
            end else begin
               if (!xleap && nr_ff >= 16'd59) nr_in = nr_ff + 16'd1;
               res_in.out_year = x_ff;
               mon_in = 4'd0;
               state_in = ST_DEC_MONTH;
            end
         end
         ST_DEC_MONTH: begin
            if (mon_ff == 4'd0) begin
               if (nr_ff <= 16'd30) begin
                  res_in.out_month = 4'd1;
                  res_in.out_day   = 5'(nr_ff + 16'd1);
                  state_in = ST_DEC_HOUR;
               end else if (nr_ff <= 16'd59) begin
                  res_in.out_month = 4'd2;
                  res_in.out_day   = 5'(nr_ff - 16'd30);
                  state_in = ST_DEC_HOUR;
               end else begin
                  nr_in  = nr_ff - 16'd60;
                  mon_in = 4'd3;
                  x_in   = 8'd31;
               end
            end else if (nr_ff >= {8'd0, x_ff}) begin
               nr_in  = nr_ff - {8'd0, x_ff};
               mon_in = mon_ff + 4'd1;
               x_in   = {3'd0, tail_month_len(mon_ff + 4'd1)};
            end else begin
               res_in.out_month = mon_ff;
               res_in.out_day   = 5'(nr_ff + 16'd1);
               state_in = ST_DEC_HOUR;
            end
            frac_in = item_ff.in_stamp[15:0];
         end
         ST_DEC_HOUR: begin
            fprod = {6'd0, frac_ff} * 22'd24;
            res_in.out_hour = fprod[20:16];
            frac_in  = fprod[15:0];
            state_in = ST_DEC_MIN;
         end
         ST_DEC_MIN: begin
            fprod = {6'd0, frac_ff} * 22'd60;
            res_in.out_minute = fprod[21:16];
            frac_in  = fprod[15:0];
            state_in = ST_DEC_SEC;
         end
         ST_DEC_SEC: begin
            fprod = {6'd0, frac_ff} * 22'd61;
            res_in.out_second = fprod[21:16];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `include "assert_macros.svh"
   `ASSERT_CLK(a_done_hold, clock, reset,
      (out_valid && !out_ready) |=> (out_valid && $stable(res_ff)), "result dropped")
   `ASSERT_CLK(a_no_overlap, clock, reset, !(in_ready && out_valid), "busy overlap")
   `ASSERT_CLK(a_dec_stamp0, clock, reset,
      (out_valid && item_ff.action == ACT_DECODE) |-> (res_ff.out_stamp == 32'd0),
      "decode stamp nonzero")
endmodule

// ===== rtl/datetime_stamp_codec_top.sv =====
// Top level of the date/time stamp codec.
// Usage:
//   req_ channel carries one conversion request per transfer; action in tuser
//   selects encode (0) or decode (1). rsp_ channel returns one result per
//   request, in order.
//   Front: a two-entry queue takes requests while the engine is busy.
//   Back: a sequencer runs the conversion, one loop step per cycle.
//   Encode time grows with the months walked after March; decode time grows
//   with the four-year groups, the further years and the month walk, and the
//   four-year loop sets the upper bound. One item at a time is in the engine;
//   it takes the next item in the cycle after each result transfer.
//   Reset clears the queue and the sequencer; no clearing pass is needed.
//   If the receiver stalls, the result holds on rsp_tdata and the queue
//   fills, after which req_tready drops.
module datetime_stamp_codec_top import dtsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // in_year, in_month, in_day, in_hour, in_minute, in_second, in_stamp, 6 pad bits
   input  logic [71:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_stamp, out_year, out_month, out_day, out_weekday, out_hour,
   // out_minute, out_second, 3 pad bits
   output logic [71:0] rsp_tdata
);
   item_type   req_item, q_item;
   result_type res;
   logic       q_valid, q_ready;

   assign req_item.action    = action_type'(req_tuser);
   assign req_item.in_year   = req_tdata[7:0];
   assign req_item.in_month  = req_tdata[11:8];
   assign req_item.in_day    = req_tdata[16:12];
   assign req_item.in_hour   = req_tdata[21:17];
   assign req_item.in_minute = req_tdata[27:22];
   assign req_item.in_second = req_tdata[33:28];
   assign req_item.in_stamp  = req_tdata[65:34];

   dtsc_fifo u_fifo (
      .clock(clock), .reset(reset),
      .wr_valid(req_tvalid), .wr_ready(req_tready), .wr_data(req_item),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
   );

   dtsc_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {3'd0, res};
endmodule
